// ----- design/mrtu_pkg.sv -----
// Package for the Modbus RTU read-registers master.
// Holds the sequencer state type, the CRC control struct and the protocol constants.
// No dependencies.
package mrtu_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RECV,
        S_REQ_CRC,
        S_REQ_TX,
        S_RX_CRC,
        S_STATUS,
        S_RD,
        S_REG
    } state_t;

    typedef struct packed {
        logic init;
        logic shift;
        logic data_bit;
    } crc_ctl_t;

    typedef logic [1:0] kind_t;
    typedef logic [1:0] status_t;

    localparam kind_t KIND_TX     = 2'd0;
    localparam kind_t KIND_REG    = 2'd1;
    localparam kind_t KIND_STATUS = 2'd2;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_BAD_FUNC = 2'd1;
    localparam status_t ST_BAD_CRC  = 2'd2;
    localparam status_t ST_TOO_MANY = 2'd3;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_BYTE  = 1'b1;

    localparam logic [7:0]  FUNC_READ = 8'd3;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;

    localparam logic [7:0] LEN_BASE = 8'd5;
    localparam logic [7:0] POS_FUNC = 8'd1;
    localparam logic [7:0] POS_DATA = 8'd3;

    localparam logic [5:0] REQ_LAST_BIT = 6'd47;
    localparam logic [5:0] RX_LAST_BIT  = 6'd7;
    localparam logic [5:0] TX_CRC_LO    = 6'd6;
    localparam logic [5:0] TX_CRC_HI    = 6'd7;

endpackage

// ----- design/mrtu_crc.sv -----
// Bit-serial CRC-16/MODBUS register, one message bit per cycle while shift is set, least significant bit first.
// Depends on mrtu_pkg for the control struct and the polynomial.
module mrtu_crc
(
    input  logic                clk,
    input  logic                rst_n,
    input  mrtu_pkg::crc_ctl_t  ctl,
    output logic [15:0]         crc
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic        feedback;

    assign feedback = crc_reg[0] ^ ctl.data_bit;

    always_comb
    begin
        crc_next = crc_reg;
        if (ctl.init)
        begin
            crc_next = mrtu_pkg::CRC_INIT;
        end
        else if (ctl.shift)
        begin
            crc_next = {1'b0, crc_reg[15:1]} ^ (feedback ? mrtu_pkg::CRC_POLY : 16'h0000);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= mrtu_pkg::CRC_INIT;
        end
        else
        begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;

endmodule

// ----- design/mrtu_store.sv -----
// Register word store: one write port and one registered read port.
// No dependencies.
module mrtu_store
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [15:0]   wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [15:0]   rd_data
);

    logic [15:0] mem [DEPTH];
    logic [15:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/modbus_rtu_read_registers_master_top.sv -----
// Modbus RTU function 3 master: request builder, response checker and register emitter.
// A start serially CRCs 48 request bits, then sends one request byte per cycle unless stalled (8 transfers).
// Each response byte is taken on input; header and data bytes then pass bit-serially through the CRC.
// After the final byte, registers leave one at a time: a store read in S_RD, then the transfer in S_REG.
// Reset is asynchronous and active low; it makes the block idle, with no clearing pass.
module modbus_rtu_read_registers_master_top
#(
    parameter int MAX_REGS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [7:0]  slave_addr,
    input  logic [15:0] start_addr,
    input  logic [5:0]  reg_count,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  tx_byte,
    output logic [5:0]  reg_index,
    output logic [15:0] reg_value,
    output logic [1:0]  status,
    output logic        last
);

    localparam int IDX_W = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
    localparam logic [6:0] MAX_N = 7'(MAX_REGS);

    mrtu_pkg::state_t   state_reg, state_next;
    logic [7:0]         pos_reg, pos_next;
    logic [7:0]         len_reg, len_next;
    logic [5:0]         count_reg, count_next;
    logic [7:0]         crc_low_reg, crc_low_next;
    logic [7:0]         pending_reg, pending_next;
    mrtu_pkg::status_t  st_reg, st_next;
    logic [5:0]         bit_cnt_reg, bit_cnt_next;
    logic [47:0]        msg_sr_reg, msg_sr_next;
    logic [7:0]         rx_sr_reg, rx_sr_next;
    logic [5:0]         emit_idx_reg, emit_idx_next;

    logic               out_valid_reg, out_valid_next;
    mrtu_pkg::kind_t    kind_reg, kind_next;
    logic [7:0]         tx_byte_reg, tx_byte_next;
    logic [5:0]         reg_index_reg, reg_index_next;
    logic [15:0]        reg_value_reg, reg_value_next;
    mrtu_pkg::status_t  status_reg, status_next;
    logic               last_reg, last_next;

    mrtu_pkg::crc_ctl_t crc_ctl;
    logic [15:0]        crc;
    logic               st_wr_en;
    logic [IDX_W-1:0]   st_wr_addr;
    logic [15:0]        st_wr_data;
    logic [15:0]        st_rd_data;

    logic               in_accept;
    logic               out_load;
    logic               out_free;
    logic [15:0]        addr_m1;
    logic [8:0]         pos_p2;
    logic [7:0]         data_k;
    logic               emit_last;

    assign in_stall  = !(state_reg == mrtu_pkg::S_IDLE || state_reg == mrtu_pkg::S_RECV);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign addr_m1   = start_addr - 16'd1;
    assign pos_p2    = {1'b0, pos_reg} + 9'd2;
    assign data_k    = pos_reg - mrtu_pkg::POS_DATA;
    assign emit_last = ({1'b0, emit_idx_reg} + 7'd1) == {1'b0, count_reg};

    mrtu_crc u_crc
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (crc_ctl),
        .crc   (crc)
    );

    mrtu_store
    #(
        .DEPTH (MAX_REGS),
        .AW    (IDX_W)
    )
    u_store
    (
        .clk     (clk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .rd_addr (emit_idx_reg[IDX_W-1:0]),
        .rd_data (st_rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        len_next       = len_reg;
        count_next     = count_reg;
        crc_low_next   = crc_low_reg;
        pending_next   = pending_reg;
        st_next        = st_reg;
        bit_cnt_next   = bit_cnt_reg;
        msg_sr_next    = msg_sr_reg;
        rx_sr_next     = rx_sr_reg;
        emit_idx_next  = emit_idx_reg;
        crc_ctl        = '0;
        st_wr_en       = 1'b0;
        st_wr_addr     = data_k[IDX_W:1];
        st_wr_data     = {rx_byte, pending_reg};
        out_load       = 1'b0;
        kind_next      = mrtu_pkg::KIND_TX;
        tx_byte_next   = 8'h00;
        reg_index_next = 6'd0;
        reg_value_next = 16'h0000;
        status_next    = mrtu_pkg::ST_OK;
        last_next      = 1'b0;

        case (state_reg)
            mrtu_pkg::S_IDLE, mrtu_pkg::S_RECV:
            begin
                if (in_accept && mode == mrtu_pkg::MODE_START)
                begin
                    if ({1'b0, reg_count} > MAX_N)
                    begin
                        st_next    = mrtu_pkg::ST_TOO_MANY;
                        state_next = mrtu_pkg::S_STATUS;
                    end
                    else
                    begin
                        msg_sr_next  = {2'b00, reg_count, 8'h00, addr_m1[7:0], addr_m1[15:8],
                                        mrtu_pkg::FUNC_READ, slave_addr};
                        count_next   = reg_count;
                        len_next     = mrtu_pkg::LEN_BASE + {1'b0, reg_count, 1'b0};
                        bit_cnt_next = 6'd0;
                        crc_ctl.init = 1'b1;
                        state_next   = mrtu_pkg::S_REQ_CRC;
                    end
                end
                else if (in_accept && state_reg == mrtu_pkg::S_RECV)
                begin
                    if (pos_reg == mrtu_pkg::POS_FUNC && rx_byte != mrtu_pkg::FUNC_READ)
                    begin
                        st_next    = mrtu_pkg::ST_BAD_FUNC;
                        state_next = mrtu_pkg::S_STATUS;
                    end
                    else if (pos_p2 < {1'b0, len_reg})
                    begin
                        rx_sr_next   = rx_byte;
                        bit_cnt_next = 6'd0;
                        pos_next     = pos_reg + 8'd1;
                        state_next   = mrtu_pkg::S_RX_CRC;
                        if (pos_reg >= mrtu_pkg::POS_DATA)
                        begin
                            if (!data_k[0])
                            begin
                                pending_next = rx_byte;
                            end
                            else
                            begin
                                st_wr_en = 1'b1;
                            end
                        end
                    end
                    else if (pos_p2 == {1'b0, len_reg})
                    begin
                        crc_low_next = rx_byte;
                        pos_next     = pos_reg + 8'd1;
                    end
                    else
                    begin
                        pos_next = 8'd0;
                        if ({rx_byte, crc_low_reg} != crc)
                        begin
                            st_next    = mrtu_pkg::ST_BAD_CRC;
                            state_next = mrtu_pkg::S_STATUS;
                        end
                        else if (count_reg == 6'd0)
                        begin
                            st_next    = mrtu_pkg::ST_OK;
                            state_next = mrtu_pkg::S_STATUS;
                        end
                        else
                        begin
                            emit_idx_next = 6'd0;
                            state_next    = mrtu_pkg::S_RD;
                        end
                    end
                end
            end

            mrtu_pkg::S_REQ_CRC:
            begin
                crc_ctl.shift    = 1'b1;
                crc_ctl.data_bit = msg_sr_reg[0];
                msg_sr_next      = {msg_sr_reg[0], msg_sr_reg[47:1]};
                bit_cnt_next     = bit_cnt_reg + 6'd1;
                if (bit_cnt_reg == mrtu_pkg::REQ_LAST_BIT)
                begin
                    bit_cnt_next = 6'd0;
                    state_next   = mrtu_pkg::S_REQ_TX;
                end
            end

            mrtu_pkg::S_REQ_TX:
            begin
                if (out_free)
                begin
                    out_load     = 1'b1;
                    kind_next    = mrtu_pkg::KIND_TX;
                    bit_cnt_next = bit_cnt_reg + 6'd1;
                    if (bit_cnt_reg == mrtu_pkg::TX_CRC_LO)
                    begin
                        tx_byte_next = crc[7:0];
                    end
                    else if (bit_cnt_reg == mrtu_pkg::TX_CRC_HI)
                    begin
                        tx_byte_next = crc[15:8];
                        last_next    = 1'b1;
                        crc_ctl.init = 1'b1;
                        pos_next     = 8'd0;
                        crc_low_next = 8'h00;
                        pending_next = 8'h00;
                        bit_cnt_next = 6'd0;
                        state_next   = mrtu_pkg::S_RECV;
                    end
                    else
                    begin
                        tx_byte_next = msg_sr_reg[7:0];
                        msg_sr_next  = {8'h00, msg_sr_reg[47:8]};
                    end
                end
            end

            mrtu_pkg::S_RX_CRC:
            begin
                crc_ctl.shift    = 1'b1;
                crc_ctl.data_bit = rx_sr_reg[0];
                rx_sr_next       = {1'b0, rx_sr_reg[7:1]};
                bit_cnt_next     = bit_cnt_reg + 6'd1;
                if (bit_cnt_reg == mrtu_pkg::RX_LAST_BIT)
                begin
                    bit_cnt_next = 6'd0;
                    state_next   = mrtu_pkg::S_RECV;
                end
            end

            mrtu_pkg::S_STATUS:
            begin
                if (out_free)
                begin
                    out_load    = 1'b1;
                    kind_next   = mrtu_pkg::KIND_STATUS;
                    status_next = st_reg;
                    last_next   = 1'b1;
                    state_next  = mrtu_pkg::S_IDLE;
                end
            end

            mrtu_pkg::S_RD:
            begin
                state_next = mrtu_pkg::S_REG;
            end

            mrtu_pkg::S_REG:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    kind_next      = mrtu_pkg::KIND_REG;
                    reg_index_next = emit_idx_reg;
                    reg_value_next = st_rd_data;
                    last_next      = emit_last;
                    if (emit_last)
                    begin
                        state_next = mrtu_pkg::S_IDLE;
                    end
                    else
                    begin
                        emit_idx_next = emit_idx_reg + 6'd1;
                        state_next    = mrtu_pkg::S_RD;
                    end
                end
            end

            default:
            begin
                state_next = mrtu_pkg::S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mrtu_pkg::S_IDLE;
            pos_reg       <= 8'd0;
            len_reg       <= 8'd0;
            count_reg     <= 6'd0;
            crc_low_reg   <= 8'h00;
            pending_reg   <= 8'h00;
            st_reg        <= mrtu_pkg::ST_OK;
            bit_cnt_reg   <= 6'd0;
            emit_idx_reg  <= 6'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            len_reg       <= len_next;
            count_reg     <= count_next;
            crc_low_reg   <= crc_low_next;
            pending_reg   <= pending_next;
            st_reg        <= st_next;
            bit_cnt_reg   <= bit_cnt_next;
            emit_idx_reg  <= emit_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        msg_sr_reg <= msg_sr_next;
        rx_sr_reg  <= rx_sr_next;
        if (out_load)
        begin
            kind_reg      <= kind_next;
            tx_byte_reg   <= tx_byte_next;
            reg_index_reg <= reg_index_next;
            reg_value_reg <= reg_value_next;
            status_reg    <= status_next;
            last_reg      <= last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign tx_byte   = tx_byte_reg;
    assign reg_index = reg_index_reg;
    assign reg_value = reg_value_reg;
    assign status    = status_reg;
    assign last      = last_reg;

    a_start_runs_crc: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && mode == mrtu_pkg::MODE_START && {1'b0, reg_count} <= MAX_N)
        |=> state_reg == mrtu_pkg::S_REQ_CRC)
        else $error("Accepted start did not begin the request CRC.");

    a_crc_to_tx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mrtu_pkg::S_REQ_CRC && bit_cnt_reg == mrtu_pkg::REQ_LAST_BIT)
        |=> state_reg == mrtu_pkg::S_REQ_TX && bit_cnt_reg == 6'd0)
        else $error("Request CRC did not hand over to transmission after 48 bits.");

    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mrtu_pkg::S_STATUS && out_free)
        |=> out_valid_reg && last_reg && state_reg == mrtu_pkg::S_IDLE)
        else $error("Status transfer was not final or did not return to idle.");

    a_reg_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == mrtu_pkg::KIND_REG)
        |-> status_reg == mrtu_pkg::ST_OK && tx_byte_reg == 8'h00)
        else $error("Register transfer carries a non-zero status or request byte.");

endmodule
